// File: rtl/tpq_pkg.sv
package tpq_pkg;

    // Default queue depth
    localparam int DEPTH_DEF = 16;

    // Field widths of one queue entry
    localparam int TASK_W = 8;
    localparam int PRIO_W = 8;
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;

    // Request data word: task id, priority, payload
    localparam int IN_W = TASK_W + PRIO_W + DATA_W;

    // Bit offsets inside the result data word
    localparam int OUT_TASK_LSB = 1;
    localparam int OUT_DATA_LSB = OUT_TASK_LSB + TASK_W;
    localparam int OUT_OCC_LSB  = OUT_DATA_LSB + DATA_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_REMOVE   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] payload;
    } entry_t;

endpackage

// File: rtl/tpq_ram.sv
module tpq_ram #(
    parameter int DEPTH = tpq_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  tpq_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output tpq_pkg::entry_t rdata
);
    import tpq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/task_priority_queue_top.sv
// Bounded priority queue of up to DEPTH (task id, priority, payload) entries kept in
// arrival order in a single-port-write, single-port-read RAM. One request is handled at a
// time and s_tready is high only while the block is idle; a finished result waits in the
// output register, so a new request can be taken before the previous result is consumed.
// Insert appends at the end when there is room; contains makes one scan pass, remove one
// compaction pass that drops every entry with the id, and extract one pass to find the
// highest priority, earliest entry winning a tie, and one compaction pass that closes the
// gap. Scan and compaction passes read one entry per cycle through the RAM read port.
// Every result carries the occupancy after the request; out_task and out_payload are zero
// except for a successful extract.
module task_priority_queue_top #(
    parameter int DEPTH = tpq_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int OUT_W = ((tpq_pkg::OUT_OCC_LSB + CW + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // task_id[7:0], priority_req[15:8], payload[47:16]
    input  logic [tpq_pkg::IN_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [tpq_pkg::OP_W-1:0] s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // success[0], out_task[8:1], out_payload[40:9], occupancy[41 +: CW], zero fill
    output logic [OUT_W-1:0]         m_tdata
);
    import tpq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    opcode_t           op_reg, op_next;
    entry_t            req_reg, req_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     wr_idx_reg, wr_idx_next;
    logic              dv_reg, dv_next;
    logic [AW-1:0]     di_reg, di_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    entry_t            best_reg, best_next;
    logic              found_reg, found_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    entry_t            ram_rdata;
    logic              issue;
    logic              drop;

    tpq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequencer: scan and compaction passes read one entry per cycle
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        dv_next       = dv_reg;
        di_next       = di_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = rd_idx_reg[AW-1:0];
        issue     = (rd_idx_reg != cnt_reg);
        drop      = 1'b0;

        // Retire the held result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next          = opcode_t'(s_tuser);
                    req_next.task_id = s_tdata[TASK_W-1:0];
                    req_next.prio    = s_tdata[TASK_W +: PRIO_W];
                    req_next.payload = s_tdata[TASK_W+PRIO_W +: DATA_W];
                    rd_idx_next      = '0;
                    wr_idx_next      = '0;
                    dv_next          = 1'b0;
                    found_next       = 1'b0;
                    case (opcode_t'(s_tuser))
                        OP_INSERT:   state_next = ST_INSERT;
                        OP_EXTRACT:  state_next = (cnt_reg == '0) ? ST_FINISH : ST_SCAN;
                        OP_CONTAINS: state_next = ST_SCAN;
                        OP_REMOVE:   state_next = ST_SHIFT;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end

            ST_INSERT:
            begin
                // Append when there is room
                if (cnt_reg != CW'(DEPTH))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = cnt_reg[AW-1:0];
                    ram_wdata  = req_reg;
                    cnt_next   = CW'(cnt_reg + 1'b1);
                    found_next = 1'b1;
                end
                state_next = ST_FINISH;
            end

            ST_SCAN:
            begin
                // Issue the next read
                dv_next = issue;
                di_next = rd_idx_reg[AW-1:0];
                if (issue)
                begin
                    rd_idx_next = CW'(rd_idx_reg + 1'b1);
                end
                // Compare the entry that came back
                if (dv_reg)
                begin
                    if (op_reg == OP_EXTRACT)
                    begin
                        if ((di_reg == '0) || (ram_rdata.prio > best_reg.prio))
                        begin
                            best_idx_next = di_reg;
                            best_next     = ram_rdata;
                        end
                    end
                    else if (ram_rdata.task_id == req_reg.task_id)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (!issue && !dv_reg)
                begin
                    if (op_reg == OP_EXTRACT)
                    begin
                        rd_idx_next = '0;
                        wr_idx_next = '0;
                        found_next  = 1'b1;
                        state_next  = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SHIFT:
            begin
                dv_next = issue;
                di_next = rd_idx_reg[AW-1:0];
                if (issue)
                begin
                    rd_idx_next = CW'(rd_idx_reg + 1'b1);
                end
                // Keep the entry unless it is dropped, writing it down to close gaps
                if (dv_reg)
                begin
                    if (op_reg == OP_EXTRACT)
                    begin
                        drop = (di_reg == best_idx_reg);
                    end
                    else
                    begin
                        drop = (ram_rdata.task_id == req_reg.task_id);
                    end
                    if (drop)
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = wr_idx_reg[AW-1:0];
                        ram_wdata   = ram_rdata;
                        wr_idx_next = CW'(wr_idx_reg + 1'b1);
                    end
                end
                if (!issue && !dv_reg)
                begin
                    cnt_next   = wr_idx_reg;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Load the result once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next    = 1'b1;
                    m_tdata_next     = '0;
                    m_tdata_next[0]  = found_reg;
                    if ((op_reg == OP_EXTRACT) && found_reg)
                    begin
                        m_tdata_next[OUT_TASK_LSB +: TASK_W] = best_reg.task_id;
                        m_tdata_next[OUT_DATA_LSB +: DATA_W] = best_reg.payload;
                    end
                    m_tdata_next[OUT_OCC_LSB +: CW] = cnt_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_INSERT;
            req_reg      <= '0;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            dv_reg       <= 1'b0;
            di_reg       <= '0;
            best_idx_reg <= '0;
            best_reg     <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            req_reg      <= req_next;
            cnt_reg      <= cnt_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            dv_reg       <= dv_next;
            di_reg       <= di_next;
            best_idx_reg <= best_idx_next;
            best_reg     <= best_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

endmodule

// File: rtl/tpq_checker.sv
module tpq_checker #(
    parameter int DEPTH = tpq_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int OUT_W = ((tpq_pkg::OUT_OCC_LSB + CW + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    import tpq_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drop ready in the cycle after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken on consecutive cycles");

    // Keep occupancy within the queue depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_OCC_LSB +: CW] <= CW'(DEPTH)))
        else $error("occupancy beyond depth");

    // Zero task and payload on a failed request
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |->
            (m_tdata[OUT_TASK_LSB +: TASK_W] == '0) && (m_tdata[OUT_DATA_LSB +: DATA_W] == '0))
        else $error("nonzero task or payload on failure");

endmodule

bind task_priority_queue_top tpq_checker #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .OUT_W (OUT_W)
) u_tpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/task_priority_queue_checker.sv
module task_priority_queue_checker #(
    parameter int DEPTH = tpq_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int OUT_W = ((tpq_pkg::OUT_OCC_LSB + CW + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // task_id[7:0], priority_req[15:8], payload[47:16]
    input  logic [tpq_pkg::IN_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [tpq_pkg::OP_W-1:0] s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // success[0], out_task[8:1], out_payload[40:9], occupancy[41 +: CW]
    input  logic [OUT_W-1:0]         m_tdata,
    output int                       mismatches,
    output int                       outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import tpq_pkg::*;

    typedef struct packed {
        logic              success;
        logic [TASK_W-1:0] task_id;
        logic [DATA_W-1:0] payload;
        logic [CW-1:0]     occupancy;
    } queue_result_t;

    // Shadow copy of the queue contents, in arrival order
    logic [TASK_W-1:0] shadow_task [DEPTH];
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    logic [DATA_W-1:0] shadow_data [DEPTH];
    int                shadow_fill;

    queue_result_t     expected_results [$];

    // Drop one slot and shift the later entries down
    function automatic void close_gap(int pos);
        for (int j = pos; j + 1 < shadow_fill; j++)
        begin
            shadow_task[j] = shadow_task[j + 1];
            shadow_prio[j] = shadow_prio[j + 1];
            shadow_data[j] = shadow_data[j + 1];
        end
        shadow_fill--;
    endfunction

    // Apply one request to the shadow queue and return the result it must produce
    function automatic queue_result_t apply_request(opcode_t op, logic [TASK_W-1:0] tid,
                                                    logic [PRIO_W-1:0] prio,
                                                    logic [DATA_W-1:0] data);
        queue_result_t res;
        int            best;
        int            i;
        res = '0;
        case (op)
            OP_INSERT:
            begin
                if (shadow_fill < DEPTH)
                begin
                    shadow_task[shadow_fill] = tid;
                    shadow_prio[shadow_fill] = prio;
                    shadow_data[shadow_fill] = data;
                    shadow_fill++;
                    res.success = 1'b1;
                end
            end
            OP_EXTRACT:
            begin
                if (shadow_fill > 0)
                begin
                    // Strictly greater keeps the earliest entry on a tie
                    best = 0;
                    for (i = 1; i < shadow_fill; i++)
                    begin
                        if (shadow_prio[i] > shadow_prio[best])
                            best = i;
                    end
                    res.success = 1'b1;
                    res.task_id = shadow_task[best];
                    res.payload = shadow_data[best];
                    close_gap(best);
                end
            end
            OP_CONTAINS:
            begin
                for (i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_task[i] == tid)
                        res.success = 1'b1;
                end
            end
            default:
            begin
                // Recheck the same slot after each shift
                i = 0;
                while (i < shadow_fill)
                begin
                    if (shadow_task[i] == tid)
                    begin
                        close_gap(i);
                        res.success = 1'b1;
                    end
                    else
                        i++;
                end
            end
        endcase
        res.occupancy = CW'(shadow_fill);
        return res;
    endfunction

    // Compare each result with the oldest prediction, then predict newly accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        queue_result_t got;
        if (!rst_n)
        begin
            shadow_fill = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.success   = m_tdata[0];
                got.task_id   = m_tdata[OUT_TASK_LSB +: TASK_W];
                got.payload   = m_tdata[OUT_DATA_LSB +: DATA_W];
                got.occupancy = m_tdata[OUT_OCC_LSB +: CW];
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.success !== want.success)
                    begin
                        $error("success: expected %0d, got %0d", want.success, got.success);
                        mismatches++;
                    end
                    if (got.task_id !== want.task_id)
                    begin
                        $error("out_task: expected %0d, got %0d", want.task_id, got.task_id);
                        mismatches++;
                    end
                    if (got.payload !== want.payload)
                    begin
                        $error("out_payload: expected %h, got %h", want.payload, got.payload);
                        mismatches++;
                    end
                    if (got.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy,
                               got.occupancy);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_request(opcode_t'(s_tuser),
                                                         s_tdata[0 +: TASK_W],
                                                         s_tdata[TASK_W +: PRIO_W],
                                                         s_tdata[TASK_W + PRIO_W +: DATA_W]));
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// File: dv/tb_task_priority_queue_top.sv
module tb_task_priority_queue_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tpq_pkg::*;

    localparam int CW            = $clog2(DEPTH_DEF + 1);
    localparam int OUT_W         = ((OUT_OCC_LSB + CW + 7) / 8) * 8;
    localparam int RANDOM_TARGET = 1050;
    localparam int SETTLE_CYCLES = 4 * DEPTH_DEF + 20;
    localparam int STALL_LIMIT   = 5000;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_SEARCH,
        MIX_UNIFORM
    } traffic_mix_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // task_id[7:0], priority_req[15:8], payload[47:16]
    logic [IN_W-1:0]  s_tdata  = '0;
    // opcode[1:0]
    logic [OP_W-1:0]  s_tuser  = OP_INSERT;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // success[0], out_task[8:1], out_payload[40:9], occupancy[41 +: CW]
    logic [OUT_W-1:0] m_tdata;

    int               mismatches;
    int               outstanding;
    int               requests_sent = 0;
    int               idle_cycles   = 0;
    bit               sender_gaps   = 1'b0;
    bit               sink_stalls   = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task_priority_queue_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    task_priority_queue_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Present one request, after a random gap when sender_gaps is set, and hold it until accepted
    task automatic send_request(opcode_t op, logic [TASK_W-1:0] tid,
                                logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] data);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, prio, tid};
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
    endtask

    // Hold off new requests until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic opcode_t pick_opcode(traffic_mix_t mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                return roll < 85 ? OP_INSERT : roll < 90 ? OP_EXTRACT :
                       roll < 95 ? OP_CONTAINS : OP_REMOVE;
            MIX_DRAIN:
                return roll < 20 ? OP_INSERT : roll < 75 ? OP_EXTRACT :
                       roll < 88 ? OP_CONTAINS : OP_REMOVE;
            MIX_SEARCH:
                return roll < 35 ? OP_INSERT : roll < 45 ? OP_EXTRACT :
                       roll < 70 ? OP_CONTAINS : OP_REMOVE;
            default:
                return opcode_t'($urandom_range(OP_INSERT, OP_REMOVE));
        endcase
    endfunction

    // One burst of requests with a traffic mix, id pool and priority spread of its own
    task automatic run_burst();
        traffic_mix_t      mix;
        bit                narrow_ids;
        bit                narrow_prio;
        int                len;
        logic [TASK_W-1:0] tid;
        logic [PRIO_W-1:0] prio;
        mix         = traffic_mix_t'($urandom_range(MIX_FILL, MIX_UNIFORM));
        narrow_ids  = $urandom_range(0, 3) != 0;
        narrow_prio = $urandom_range(0, 2) == 0;
        sender_gaps = $urandom_range(0, 3) != 0;
        len         = $urandom_range(10, 50);
        repeat (len)
        begin
            if (narrow_ids)
                tid = 8'($urandom_range(0, 3)) ^ (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
            else
                tid = 8'($urandom());
            prio = narrow_prio ? 8'($urandom_range(0, 3)) : 8'($urandom());
            send_request(pick_opcode(mix), tid, prio, $urandom());
        end
    endtask

    // Accept results after a random stall, with stall-free stretches
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_stalls = !sink_stalls;
            stall = sink_stalls ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_task_priority_queue_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int bursts;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: every lookup misses
        send_request(OP_EXTRACT, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_CONTAINS, 8'h00, 8'h00, 32'h0);
        send_request(OP_REMOVE, 8'hFF, 8'h00, 32'h0);
        // Field extremes, a priority tie and a duplicate id
        send_request(OP_INSERT, 8'h00, 8'h00, 32'h0000_0000);
        send_request(OP_INSERT, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'h5A, 8'hFF, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 8'hFF, 8'h80, 32'h1234_5678);
        send_request(OP_CONTAINS, 8'hFF, 8'h00, 32'h0);
        send_request(OP_CONTAINS, 8'h5A, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_CONTAINS, 8'h01, 8'h00, 32'h0);
        // Earliest of the tied entries comes out first
        send_request(OP_EXTRACT, 8'h00, 8'h00, 32'h0);
        send_request(OP_REMOVE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 8'hFF, 8'h00, 32'h0);
        send_request(OP_INSERT, 8'h5A, 8'h01, 32'h0F0F_0F0F);
        send_request(OP_INSERT, 8'h5A, 8'h01, 32'hF0F0_F0F0);
        send_request(OP_REMOVE, 8'h5A, 8'h00, 32'h0);
        send_request(OP_EXTRACT, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_EXTRACT, 8'h00, 8'h00, 32'h0);
        drain_results();

        // Random bursts, draining now and then
        bursts = 0;
        while (requests_sent < RANDOM_TARGET)
        begin
            run_burst();
            bursts++;
            if (bursts % 6 == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_task_priority_queue_top: PASS");
        else
            $display("tb_task_priority_queue_top: FAIL");
        $finish;
    end

endmodule
